@@ rtl/u32u16_pkg.sv @@
package u32u16_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned PARTIAL_W   = 24;
    localparam int unsigned CP_W        = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [UNIT_W-1:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [5:0]        HIGH_SURR_TAG    = 6'b110110;
    localparam logic [5:0]        LOW_SURR_TAG     = 6'b110111;
    localparam logic [4:0]        SURR_RANGE_TAG   = 5'b11011;
    localparam logic [4:0]        LAST_PLANE       = 5'h10;
    localparam logic [20:0]       PLANE1_START     = 21'h010000;
    localparam logic [1:0]        LAST_BYTE_POS    = 2'd3;

    typedef struct packed {
        logic              pair;
        logic [UNIT_W-1:0] first_unit;
        logic [UNIT_W-1:0] second_unit;
    } unit_entry_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

endpackage

@@ rtl/u32u16_front.sv @@
module u32u16_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             little_endian,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [u32u16_pkg::BYTE_W-1:0]    s_tdata,
    output u32u16_pkg::unit_entry_t          entry,
    input  logic                             queue_full,
    output logic                             push
);

    logic [1:0]                          bytes_held_reg, bytes_held_next;
    logic [u32u16_pkg::PARTIAL_W-1:0]    partial_reg, partial_next;
    logic [u32u16_pkg::CP_W-1:0]         assembled;
    logic [u32u16_pkg::CP_W-1:0]         cp;
    logic [19:0]                         offset;
    logic                                group_end;
    logic                                accept;

    assign group_end = (bytes_held_reg == u32u16_pkg::LAST_BYTE_POS);
    assign s_tready  = !group_end || !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept && group_end;

    assign assembled = {partial_reg, s_tdata};
    assign cp = little_endian ?
        {assembled[7:0], assembled[15:8], assembled[23:16], assembled[31:24]} : assembled;
    assign offset = 20'(cp[20:0] - u32u16_pkg::PLANE1_START);

    always_comb begin
        entry.pair        = 1'b0;
        entry.first_unit  = u32u16_pkg::REPLACEMENT_UNIT;
        entry.second_unit = {u32u16_pkg::LOW_SURR_TAG, offset[9:0]};
        if (cp[31:16] == 16'h0000) begin
            if (cp[15:11] != u32u16_pkg::SURR_RANGE_TAG) begin
                entry.first_unit = cp[15:0];
            end
        end else if (cp[31:21] == 11'd0 && cp[20:16] <= u32u16_pkg::LAST_PLANE) begin
            entry.pair       = 1'b1;
            entry.first_unit = {u32u16_pkg::HIGH_SURR_TAG, offset[19:10]};
        end
    end

    always_comb begin
        bytes_held_next = bytes_held_reg;
        partial_next    = partial_reg;
        if (accept) begin
            if (group_end) begin
                bytes_held_next = 2'd0;
                partial_next    = '0;
            end else begin
                bytes_held_next = bytes_held_reg + 2'd1;
                partial_next    = {partial_reg[15:0], s_tdata};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_held_reg <= 2'd0;
            partial_reg    <= '0;
        end else begin
            bytes_held_reg <= bytes_held_next;
            partial_reg    <= partial_next;
        end
    end

endmodule

@@ rtl/u32u16_queue.sv @@
module u32u16_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  u32u16_pkg::queue_wr_t   wr_ctl,
    output logic                    full,
    input  u32u16_pkg::unit_entry_t wr_entry,
    input  logic                    pop,
    output logic                    not_empty,
    output u32u16_pkg::unit_entry_t rd_entry
);

    u32u16_pkg::unit_entry_t entries_reg [u32u16_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'(u32u16_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign rd_entry  = entries_reg[rd_ptr_reg];
    assign do_push   = wr_ctl.push && !wr_ctl.full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/u32u16_back.sv @@
module u32u16_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             not_empty,
    input  u32u16_pkg::unit_entry_t          rd_entry,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [u32u16_pkg::UNIT_W-1:0]    m_tdata,
    output logic                             m_tlast
);

    logic                            valid_reg, valid_next;
    logic                            pending_reg, pending_next;
    logic [u32u16_pkg::UNIT_W-1:0]   low_reg, low_next;
    logic [u32u16_pkg::UNIT_W-1:0]   data_reg, data_next;
    logic                            last_reg, last_next;
    logic                            slot_free;

    assign slot_free = !valid_reg || m_tready;
    assign pop       = slot_free && !pending_reg && not_empty;

    always_comb begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        low_next     = low_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        if (slot_free) begin
            if (pending_reg) begin
                valid_next   = 1'b1;
                data_next    = low_reg;
                last_next    = 1'b1;
                pending_next = 1'b0;
            end else if (not_empty) begin
                valid_next   = 1'b1;
                data_next    = rd_entry.first_unit;
                last_next    = !rd_entry.pair;
                pending_next = rd_entry.pair;
                low_next     = rd_entry.second_unit;
            end else begin
                valid_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
        low_reg  <= low_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/utf32_to_utf16_decoder.sv @@
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata[7:0] = in_byte
// m_        out  m_tvalid/m_tready    m_tdata[15:0] = code_unit, m_tlast = last_of_run
// cfg_      in   cfg_valid/cfg_ready  cfg_data[0] = little_endian
//
// Registered output; one byte in and one code unit out per cycle unless stalled.
// The fourth byte of a group classifies the code point and enters a two-entry queue;
// the output stage sends one unit for an entry, or two for a surrogate pair.
// Reset (aresetn low, synchronous) drops held bytes and queued units; little_endian clears.
// A stalled m_ side fills the queue; s_ then stalls only on a group's fourth byte.
module utf32_to_utf16_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [u32u16_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [u32u16_pkg::UNIT_W-1:0]    m_tdata,   // [15:0] code_unit
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data
);

    logic                    little_endian_reg;
    u32u16_pkg::unit_entry_t wr_entry;
    u32u16_pkg::unit_entry_t rd_entry;
    u32u16_pkg::queue_wr_t   wr_ctl;
    logic                    queue_full;
    logic                    push;
    logic                    pop;
    logic                    not_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            little_endian_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            little_endian_reg <= cfg_data;
        end
    end

    assign wr_ctl.push = push;
    assign wr_ctl.full = queue_full;

    u32u16_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .little_endian (little_endian_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .entry         (wr_entry),
        .queue_full    (wr_ctl.full),
        .push          (push)
    );

    u32u16_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_ctl    (wr_ctl),
        .full      (queue_full),
        .wr_entry  (wr_entry),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_entry  (rd_entry)
    );

    u32u16_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .rd_entry  (rd_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
